@@ hw/rtl/dll_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list engine package
// Request and result types, command and status codes, and sequencer states
// that the list engine modules share.
// ----------------------------------------------------------------------------
package dll_pkg;

  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  localparam int ELEM_W  = 32;
  localparam int STAT_W  = 2;
  localparam int LEN_W   = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT     = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_WALK_FWD   = 3'd5,
    CMD_WALK_REV   = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
  } in_req_t;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;
    logic              last;
  } out_res_t;

  // Write strobes from the sequencer to the slot and free-slot memories.
  typedef struct packed {
    logic data_we;
    logic next_we;
    logic prev_we;
    logic free_we;
  } store_we_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP,
    S_SEEK,
    S_LINK,
    S_EMIT,
    S_WALK
  } state_t;

endpackage

@@ hw/rtl/dll_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list slot storage
// Slot data, next and previous link memories with one registered read port,
// and the free-slot stack whose unwritten entries read as their own index.
// ----------------------------------------------------------------------------
module dll_store #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dll_pkg::store_we_t          we,
  input  logic [$clog2(CAPACITY)-1:0] data_addr,
  input  logic [DATA_WIDTH-1:0]       data_wdata,
  input  logic [$clog2(CAPACITY)-1:0] next_addr,
  input  logic [$clog2(CAPACITY)-1:0] next_wdata,
  input  logic [$clog2(CAPACITY)-1:0] prev_addr,
  input  logic [$clog2(CAPACITY)-1:0] prev_wdata,
  input  logic [$clog2(CAPACITY)-1:0] free_addr,
  input  logic [$clog2(CAPACITY)-1:0] free_wdata,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr,
  input  logic [$clog2(CAPACITY)-1:0] free_rd_addr,
  output logic [DATA_WIDTH-1:0]       data_rd,
  output logic [$clog2(CAPACITY)-1:0] next_rd,
  output logic [$clog2(CAPACITY)-1:0] prev_rd,
  output logic [$clog2(CAPACITY)-1:0] free_rd
);
  import dll_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);

  logic [DATA_WIDTH-1:0] data_mem [CAPACITY];
  logic [SLOT_W-1:0]     next_mem [CAPACITY];
  logic [SLOT_W-1:0]     prev_mem [CAPACITY];
  logic [SLOT_W-1:0]     free_mem [CAPACITY];
  logic [CAPACITY-1:0]   free_vld_r;

  logic [DATA_WIDTH-1:0] data_rd_r;
  logic [SLOT_W-1:0]     next_rd_r;
  logic [SLOT_W-1:0]     prev_rd_r;
  logic [SLOT_W-1:0]     free_rd_r;

  always_ff @(posedge clk) begin
    if (we.data_we) begin
      data_mem[data_addr] <= data_wdata;
    end
    if (we.next_we) begin
      next_mem[next_addr] <= next_wdata;
    end
    if (we.prev_we) begin
      prev_mem[prev_addr] <= prev_wdata;
    end
    if (we.free_we) begin
      free_mem[free_addr] <= free_wdata;
    end
    data_rd_r <= data_mem[rd_addr];
    next_rd_r <= next_mem[rd_addr];
    prev_rd_r <= prev_mem[rd_addr];
    free_rd_r <= free_vld_r[free_rd_addr] ? free_mem[free_rd_addr] : free_rd_addr;
  end

  // A free-stack entry holds its own index until it is first written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_vld_r <= '0;
    end else if (we.free_we) begin
      free_vld_r[free_addr] <= 1'b1;
    end
  end

  assign data_rd = data_rd_r;
  assign next_rd = next_rd_r;
  assign prev_rd = prev_rd_r;
  assign free_rd = free_rd_r;

endmodule

@@ hw/rtl/dll_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list sequencer
// Decodes each request and steps a shared link-following cursor through the
// slot memories for pops, positioned inserts and walks.
// ----------------------------------------------------------------------------
module dll_ctrl #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dll_pkg::in_req_t            in_req,
  output logic                        emit_valid,
  input  logic                        emit_ready,
  output dll_pkg::out_res_t           emit_res,
  output dll_pkg::store_we_t          we,
  output logic [$clog2(CAPACITY)-1:0] data_addr,
  output logic [DATA_WIDTH-1:0]       data_wdata,
  output logic [$clog2(CAPACITY)-1:0] next_addr,
  output logic [$clog2(CAPACITY)-1:0] next_wdata,
  output logic [$clog2(CAPACITY)-1:0] prev_addr,
  output logic [$clog2(CAPACITY)-1:0] prev_wdata,
  output logic [$clog2(CAPACITY)-1:0] free_addr,
  output logic [$clog2(CAPACITY)-1:0] free_wdata,
  output logic [$clog2(CAPACITY)-1:0] rd_addr,
  output logic [$clog2(CAPACITY)-1:0] free_rd_addr,
  input  logic [DATA_WIDTH-1:0]       data_rd,
  input  logic [$clog2(CAPACITY)-1:0] next_rd,
  input  logic [$clog2(CAPACITY)-1:0] prev_rd,
  input  logic [$clog2(CAPACITY)-1:0] free_rd
);
  import dll_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  state_t                state_r, state_nxt;
  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [DATA_WIDTH-1:0] value_r, value_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [SLOT_W-1:0]     head_r, head_nxt;
  logic [SLOT_W-1:0]     tail_r, tail_nxt;
  logic [SLOT_W-1:0]     cur_r, cur_nxt;
  logic [SLOT_W-1:0]     link_r, link_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      steps_r, steps_nxt;
  logic                  fwd_r, fwd_nxt;
  logic [STAT_W-1:0]     status_r, status_nxt;

  logic [CMP_W-1:0]  cnt_x, pos_x;
  logic [63:0]       value_ext, data_ext;
  logic              is_empty, is_full, beyond, near_head, ins_front, ins_back;
  logic              cmd_fwd, is_walk;
  logic [SLOT_W-1:0] step_slot;
  logic              disp_push, disp_front;
  logic [STAT_W-1:0] disp_status;
  state_t            disp_state;

  assign cnt_x     = CMP_W'(count_r);
  assign pos_x     = CMP_W'(pos_r);
  assign value_ext = 64'(in_req.value);
  assign data_ext  = 64'(data_rd);
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign beyond    = (pos_x > cnt_x);
  assign near_head = (pos_x < (cnt_x >> 1));
  assign ins_front = (pos_r == '0);
  assign ins_back  = (pos_x == cnt_x);
  assign is_walk   = (cmd_r == CMD_WALK_FWD) || (cmd_r == CMD_WALK_REV);
  assign cmd_fwd   = (cmd_r == CMD_POP_FRONT) || (cmd_r == CMD_WALK_FWD) ||
                     ((cmd_r == CMD_INSERT) && near_head);
  assign step_slot = fwd_r ? next_rd : prev_rd;

  // Command decode, evaluated in the dispatch state.
  always_comb begin
    disp_push   = 1'b0;
    disp_front  = 1'b0;
    disp_status = ST_OK;
    disp_state  = S_EMIT;
    case (cmd_r)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (is_full) begin
          disp_status = ST_FULL;
        end else begin
          disp_push  = 1'b1;
          disp_front = (cmd_r == CMD_PUSH_FRONT);
        end
      end
      CMD_INSERT: begin
        if (beyond) begin
          disp_status = ST_RANGE;
        end else if (is_full) begin
          disp_status = ST_FULL;
        end else if (ins_front) begin
          disp_push  = 1'b1;
          disp_front = 1'b1;
        end else if (ins_back) begin
          disp_push = 1'b1;
        end else begin
          disp_state = S_SEEK;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (is_empty) begin
          disp_status = ST_EMPTY;
        end else begin
          disp_state = S_POP;
        end
      end
      CMD_WALK_FWD, CMD_WALK_REV: begin
        if (is_empty) begin
          disp_status = ST_EMPTY;
        end else begin
          disp_state = S_WALK;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: state_nxt = disp_state;
      S_POP:      state_nxt = S_EMIT;
      S_SEEK: begin
        if (steps_r == '0) begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: state_nxt = S_EMIT;
      S_EMIT: begin
        if (emit_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        if (emit_ready && (steps_r == CNT_W'(1))) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt    = cmd_r;
    value_nxt  = value_r;
    pos_nxt    = pos_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cur_nxt    = cur_r;
    link_nxt   = link_r;
    count_nxt  = count_r;
    steps_nxt  = steps_r;
    fwd_nxt    = fwd_r;
    status_nxt = status_r;
    we         = '0;
    data_addr  = free_rd;
    data_wdata = value_r;
    next_addr  = '0;
    next_wdata = '0;
    prev_addr  = '0;
    prev_wdata = '0;
    free_addr  = SLOT_W'(count_r - CNT_W'(1));
    free_wdata = cur_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_req.cmd;
          value_nxt = value_ext[DATA_WIDTH-1:0];
          pos_nxt   = in_req.position;
        end
      end
      S_DISPATCH: begin
        status_nxt = disp_status;
        fwd_nxt    = cmd_fwd;
        cur_nxt    = cmd_fwd ? head_r : tail_r;
        if (is_walk) begin
          steps_nxt = count_r;
        end else if (near_head) begin
          steps_nxt = CNT_W'(pos_x);
        end else begin
          steps_nxt = CNT_W'(cnt_x - pos_x - CMP_W'(1));
        end
        if (disp_push) begin
          we.data_we = 1'b1;
          count_nxt  = count_r + CNT_W'(1);
          if (is_empty) begin
            head_nxt = free_rd;
            tail_nxt = free_rd;
          end else if (disp_front) begin
            we.next_we = 1'b1;
            next_addr  = free_rd;
            next_wdata = head_r;
            we.prev_we = 1'b1;
            prev_addr  = head_r;
            prev_wdata = free_rd;
            head_nxt   = free_rd;
          end else begin
            we.prev_we = 1'b1;
            prev_addr  = free_rd;
            prev_wdata = tail_r;
            we.next_we = 1'b1;
            next_addr  = tail_r;
            next_wdata = free_rd;
            tail_nxt   = free_rd;
          end
        end
      end
      S_POP: begin
        // The released slot goes back on the free stack.
        we.free_we = 1'b1;
        count_nxt  = count_r - CNT_W'(1);
        if (count_r == CNT_W'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end else if (fwd_r) begin
          head_nxt = next_rd;
        end else begin
          tail_nxt = prev_rd;
        end
      end
      S_SEEK: begin
        if (steps_r != '0) begin
          cur_nxt   = step_slot;
          steps_nxt = steps_r - CNT_W'(1);
        end else begin
          // The cursor is the element that the new one goes in front of.
          we.data_we = 1'b1;
          we.next_we = 1'b1;
          next_addr  = free_rd;
          next_wdata = cur_r;
          we.prev_we = 1'b1;
          prev_addr  = cur_r;
          prev_wdata = free_rd;
          link_nxt   = prev_rd;
        end
      end
      S_LINK: begin
        we.prev_we = 1'b1;
        prev_addr  = free_rd;
        prev_wdata = link_r;
        we.next_we = 1'b1;
        next_addr  = link_r;
        next_wdata = free_rd;
        count_nxt  = count_r + CNT_W'(1);
      end
      S_WALK: begin
        if (emit_ready) begin
          cur_nxt   = step_slot;
          steps_nxt = steps_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    value_r  <= value_nxt;
    pos_r    <= pos_nxt;
    cur_r    <= cur_nxt;
    link_r   <= link_nxt;
    steps_r  <= steps_nxt;
    fwd_r    <= fwd_nxt;
    status_r <= status_nxt;
  end

  assign in_ready     = (state_r == S_IDLE);
  assign rd_addr      = cur_nxt;
  assign free_rd_addr = is_full ? '0 : SLOT_W'(count_r);
  assign emit_valid   = (state_r == S_EMIT) || (state_r == S_WALK);

  always_comb begin
    emit_res.length = cnt_x[LEN_W-1:0];
    if (state_r == S_WALK) begin
      emit_res.element = data_ext[ELEM_W-1:0];
      emit_res.status  = ST_OK;
      emit_res.last    = (steps_r == CNT_W'(1));
    end else begin
      emit_res.element = '0;
      emit_res.status  = status_r;
      emit_res.last    = 1'b1;
    end
  end

endmodule

@@ hw/rtl/doubly_linked_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Doubly linked list engine
// Bounded doubly linked list with push, pop, positioned insert and walks.
// ----------------------------------------------------------------------------
// Usage: a request (cmd, value, position) is taken on in_valid/in_ready.
// The engine works on one request at a time; in_ready is high only while it
// waits for a request. Every request gives one result on out_valid/out_ready,
// except a walk of a non-empty list, which gives one result per element,
// front to back or back to front, with last set on the final one.
// Flow: push and push-like inserts go from dispatch straight to the result,
// pops pass through the pop state, and an insert in the middle seeks from
// the nearer end, since the cursor follows one link per cycle through the
// single read port of the slot memories. A walk delivers one element per
// cycle while the receiver does not stall.
// The engine is ready again in the cycle after its final result enters the
// output register, so it takes no new request before the last one is done.
// A result register sits at the output, so the next request is accepted while
// the last result still waits; a stalled receiver holds a walk on its current
// element. Reset empties the list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dll_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output dll_pkg::out_res_t out_res
);
  import dll_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);

  // Handshake between the sequencer and the result register.
  logic     emit_valid;
  logic     emit_ready;
  out_res_t emit_res;

  // Result register.
  logic     out_valid_r;
  out_res_t out_res_r;

  // Storage ports.
  store_we_t             we;
  logic [SLOT_W-1:0]     data_addr;
  logic [DATA_WIDTH-1:0] data_wdata;
  logic [SLOT_W-1:0]     next_addr;
  logic [SLOT_W-1:0]     next_wdata;
  logic [SLOT_W-1:0]     prev_addr;
  logic [SLOT_W-1:0]     prev_wdata;
  logic [SLOT_W-1:0]     free_addr;
  logic [SLOT_W-1:0]     free_wdata;
  logic [SLOT_W-1:0]     rd_addr;
  logic [SLOT_W-1:0]     free_rd_addr;
  logic [DATA_WIDTH-1:0] data_rd;
  logic [SLOT_W-1:0]     next_rd;
  logic [SLOT_W-1:0]     prev_rd;
  logic [SLOT_W-1:0]     free_rd;

  dll_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req       (in_req),
    .emit_valid   (emit_valid),
    .emit_ready   (emit_ready),
    .emit_res     (emit_res),
    .we           (we),
    .data_addr    (data_addr),
    .data_wdata   (data_wdata),
    .next_addr    (next_addr),
    .next_wdata   (next_wdata),
    .prev_addr    (prev_addr),
    .prev_wdata   (prev_wdata),
    .free_addr    (free_addr),
    .free_wdata   (free_wdata),
    .rd_addr      (rd_addr),
    .free_rd_addr (free_rd_addr),
    .data_rd      (data_rd),
    .next_rd      (next_rd),
    .prev_rd      (prev_rd),
    .free_rd      (free_rd)
  );

  dll_store #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .we           (we),
    .data_addr    (data_addr),
    .data_wdata   (data_wdata),
    .next_addr    (next_addr),
    .next_wdata   (next_wdata),
    .prev_addr    (prev_addr),
    .prev_wdata   (prev_wdata),
    .free_addr    (free_addr),
    .free_wdata   (free_wdata),
    .rd_addr      (rd_addr),
    .free_rd_addr (free_rd_addr),
    .data_rd      (data_rd),
    .next_rd      (next_rd),
    .prev_rd      (prev_rd),
    .free_rd      (free_rd)
  );

  // The result register takes a new result when it is empty or is being
  // drained in the same cycle.
  assign emit_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      out_res_r <= emit_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // A request is only taken while the sequencer produces no result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !(emit_valid && emit_ready))
    else $error("request accepted while a result was being produced");

  // The engine is busy in the cycle after it takes a request.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("engine ready again right after accepting a request");

  // Any refused command finishes with a single, final result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_res.status == ST_OK) || out_res.last))
    else $error("error status on a result that is not the last");

  // Element data appears only on walk results, which carry an ok status.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_res.status != ST_OK)) |-> (out_res.element == '0))
    else $error("element data on a refused command");

endmodule
